/* rtl/scpc_pkg.sv */
// ----------------------------------------------------------------------------
// scpc_pkg
// constants and types shared by the segment against convex hull clip block
// ----------------------------------------------------------------------------
package scpc_pkg;

    localparam int MAX_PLANES = 64;
    localparam int PIDX_W     = $clog2(MAX_PLANES);
    localparam int CNT_W      = PIDX_W + 1;

    localparam int S_DATA_W = 232;
    localparam int M_DATA_W = 136;
    localparam int ADDR_W   = 3;
    localparam int ACC_W    = 52;
    localparam int Q_W      = 33;
    localparam int DIV_STEPS = 33;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic REG_PLANE_COUNT = 1'b0;

    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_RD   = 8'b0000_0010,
        ST_MUL  = 8'b0000_0100,
        ST_ACC  = 8'b0000_1000,
        ST_DIVP = 8'b0001_0000,
        ST_DIV  = 8'b0010_0000,
        ST_UPD  = 8'b0100_0000,
        ST_FIN  = 8'b1000_0000
    } state_t;

endpackage

/* rtl/segment_convex_polyhedron_clip.sv */
// ----------------------------------------------------------------------------
// segment_convex_polyhedron_clip
// clips a segment against a table of bounding planes and reports the entry
// ----------------------------------------------------------------------------
// usage
// s_ channel: one transaction either loads a plane (tuser = 0) into the
//   plane table, giving no result, or runs a segment query (tuser = 1).
// m_ channel: one transaction per query with hit in tuser and the entry
//   fraction, plane index and plane normal in tdata.
// apb port: register plane_count at address 0, read back on prdata.
// sequence: a load does not leave the idle state. a query visits each counted plane in turn:
//   each plane needs one table read, six products through the single
//   32 x 33 multiplier with an accumulate after each, a divider set-up
//   step and 33 steps of the shared restoring divider, then one update
//   step. a plane parallel to the segment skips the divider, and a miss ends early.
// s_tready is high only while the sequencer is idle. a finished result is
//   held in the output register until m_tready, and a new transaction is
//   taken meanwhile; a further result waits in the final state.
// reset: aresetn (synchronous, active low) clears the sequencer, the output
//   valid and plane_count. the plane table is not cleared; only loaded
//   planes may be used by a query.
// ----------------------------------------------------------------------------
module segment_convex_polyhedron_clip (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // plane_slot, a_x, a_y, a_z, a_w, end_x, end_y, end_z
    input  logic [scpc_pkg::S_DATA_W-1:0] s_tdata,
    // operation
    input  logic                          s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // hit_fraction, hit_plane, normal_x, normal_y, normal_z
    output logic [scpc_pkg::M_DATA_W-1:0] m_tdata,
    // hit
    output logic                          m_tuser,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [scpc_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import scpc_pkg::*;

    state_t state_reg, state_next;

    logic [127:0]        mem [MAX_PLANES];
    logic [127:0]        rdata_reg;
    logic [6:0]          plane_count_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    idx_reg;
    logic [2:0]          step_reg;
    logic [5:0]          dcnt_reg;

    logic signed [31:0]  p1_reg [3];
    logic signed [32:0]  d_reg [3];
    logic signed [31:0]  lower_reg, upper_reg;
    logic signed [64:0]  prod_reg;
    logic signed [ACC_W-1:0] accp_reg, accd_reg;
    logic [ACC_W-1:0]    rem_reg, ud_reg;
    logic [Q_W-1:0]      dq_reg;
    logic                ovf_reg, qneg_reg, dneg_reg;
    logic                found_reg;
    logic [CNT_W-1:0]    best_reg;
    logic [95:0]         bestn_reg;

    logic                out_valid_reg, out_hit_reg;
    logic [M_DATA_W-1:0] out_data_reg;

    logic                s_acc, m_free, cfg_wr;
    logic [CNT_W-1:0]    cnt_clamp;
    logic [1:0]          comp;
    logic signed [31:0]  mul_a;
    logic signed [32:0]  mul_b;
    logic signed [ACC_W-1:0] num_w, den_w;
    logic [ACC_W-1:0]    un_w, ud_w;
    logic [ACC_W:0]      trial;
    logic signed [31:0]  q_w, lower_new, upper_new;
    logic                upd_low;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign m_free   = !out_valid_reg || m_tready;
    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && (paddr[2] == REG_PLANE_COUNT);
    assign prdata   = (paddr[2] == REG_PLANE_COUNT) ? {25'd0, plane_count_reg} : 32'd0;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_hit_reg;

    assign cnt_clamp = (32'(plane_count_reg) > MAX_PLANES) ? CNT_W'(MAX_PLANES)
                                                          : CNT_W'(plane_count_reg);

    always_comb begin
        comp = (step_reg < 3'd3) ? step_reg[1:0] : 2'(step_reg - 3'd3);
        mul_a = $signed(rdata_reg[32*comp +: 32]);
        mul_b = (step_reg < 3'd3) ? 33'(p1_reg[comp]) : d_reg[comp];
    end

    assign num_w = ACC_W'($signed(rdata_reg[127:96])) - accp_reg;
    assign den_w = accd_reg;
    assign un_w  = num_w[ACC_W-1] ? ACC_W'(-num_w) : ACC_W'(num_w);
    assign ud_w  = den_w[ACC_W-1] ? ACC_W'(-den_w) : ACC_W'(den_w);
    assign trial = {rem_reg, dq_reg[Q_W-1]} - {1'b0, ud_reg};

    always_comb begin
        if (qneg_reg) begin
            if (ovf_reg || dq_reg > 33'h0_8000_0000) q_w = 32'sh8000_0000;
            else q_w = 32'(-$signed({1'b0, dq_reg}));
        end else begin
            if (ovf_reg || dq_reg > 33'h0_7FFF_FFFF) q_w = 32'sh7FFF_FFFF;
            else q_w = $signed(dq_reg[31:0]);
        end
        upd_low   = dneg_reg && (q_w > lower_reg);
        lower_new = upd_low ? q_w : lower_reg;
        upper_new = (!dneg_reg && (q_w < upper_reg)) ? q_w : upper_reg;
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_acc && s_tuser == OP_QUERY) begin
                    state_next = (cnt_clamp == '0) ? ST_FIN : ST_RD;
                end
            end
            ST_RD:   state_next = ST_MUL;
            ST_MUL:  state_next = ST_ACC;
            ST_ACC:  state_next = (step_reg == 3'd5) ? ST_DIVP : ST_MUL;
            ST_DIVP: begin
                if (den_w == '0) begin
                    if (num_w < 0) state_next = ST_FIN;
                    else if (idx_reg + 1'b1 == count_reg) state_next = ST_FIN;
                    else state_next = ST_RD;
                end else begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:  state_next = (dcnt_reg == 6'(DIV_STEPS - 1)) ? ST_UPD : ST_DIV;
            ST_UPD: begin
                if (upper_new < lower_new || idx_reg + 1'b1 == count_reg) begin
                    state_next = ST_FIN;
                end else begin
                    state_next = ST_RD;
                end
            end
            ST_FIN:  state_next = m_free ? ST_IDLE : ST_FIN;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            plane_count_reg <= '0;
            out_valid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr) plane_count_reg <= pwdata[6:0];
            if (state_reg == ST_FIN && m_free) out_valid_reg <= 1'b1;
            else if (m_tready) out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc && s_tuser == OP_LOAD && 32'(s_tdata[5:0]) < MAX_PLANES) begin
            mem[PIDX_W'(s_tdata[5:0])] <= s_tdata[133:6];
        end
        rdata_reg <= mem[idx_reg[PIDX_W-1:0]];
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                for (int k = 0; k < 3; k++) begin
                    p1_reg[k] <= $signed(s_tdata[6+32*k +: 32]);
                    d_reg[k]  <= 33'($signed(s_tdata[134+32*k +: 32]))
                               - 33'($signed(s_tdata[6+32*k +: 32]));
                end
                upper_reg <= $signed(s_tdata[133:102]);
                lower_reg <= '0;
                found_reg <= 1'b0;
                best_reg  <= '0;
                bestn_reg <= '0;
                idx_reg   <= '0;
                count_reg <= cnt_clamp;
                step_reg  <= '0;
                accp_reg  <= '0;
                accd_reg  <= '0;
            end
            ST_MUL: prod_reg <= mul_a * mul_b;
            ST_ACC: begin
                if (step_reg < 3'd3) accp_reg <= accp_reg + ACC_W'(prod_reg >>> 16);
                else accd_reg <= accd_reg + ACC_W'(prod_reg >>> 16);
                step_reg <= (step_reg == 3'd5) ? 3'd0 : step_reg + 3'd1;
            end
            ST_DIVP: begin
                ovf_reg  <= {17'd0, un_w} >= {ud_w, 17'd0};
                rem_reg  <= un_w >> 17;
                dq_reg   <= {un_w[16:0], 16'd0};
                ud_reg   <= ud_w;
                qneg_reg <= num_w[ACC_W-1] ^ den_w[ACC_W-1];
                dneg_reg <= den_w[ACC_W-1];
                dcnt_reg <= '0;
                if (den_w == '0) begin
                    if (num_w < 0) found_reg <= 1'b0;
                    idx_reg  <= idx_reg + 1'b1;
                    accp_reg <= '0;
                    accd_reg <= '0;
                end
            end
            ST_DIV: begin
                if (!trial[ACC_W]) begin
                    rem_reg <= trial[ACC_W-1:0];
                    dq_reg  <= {dq_reg[Q_W-2:0], 1'b1};
                end else begin
                    rem_reg <= {rem_reg[ACC_W-2:0], dq_reg[Q_W-1]};
                    dq_reg  <= {dq_reg[Q_W-2:0], 1'b0};
                end
                dcnt_reg <= dcnt_reg + 6'd1;
            end
            ST_UPD: begin
                lower_reg <= lower_new;
                upper_reg <= upper_new;
                if (upd_low) begin
                    found_reg <= 1'b1;
                    best_reg  <= idx_reg;
                    bestn_reg <= rdata_reg[95:0];
                end
                if (upper_new < lower_new) found_reg <= 1'b0;
                idx_reg  <= idx_reg + 1'b1;
                accp_reg <= '0;
                accd_reg <= '0;
            end
            default: ;
        endcase
        if (state_reg == ST_FIN && m_free) begin
            out_hit_reg <= found_reg;
            if (found_reg) begin
                out_data_reg <= {3'd0, bestn_reg, 6'(best_reg), lower_reg[30:0]};
            end else begin
                out_data_reg <= '0;
            end
        end
    end

`ifndef SYNTH
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata == '0)
        else $error("miss result with non-zero payload");

    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_RD |-> idx_reg < count_reg)
        else $error("plane index beyond count");
`endif

endmodule
